@@ sv/cdda_pkg.sv @@
// Package for the calendar date day adjuster: command and status types
// shared by the controller and the datapath, calendar constants and tables.
// Depends on nothing.
`timescale 1ns / 1ps

package cdda_pkg;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_ADJUST = 1'b1;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [13:0] YEAR_MIN      = 14'd1;
  localparam logic [13:0] YEAR_MAX      = 14'd9999;
  localparam logic [13:0] CENTURY_BASE  = 14'd2000;
  localparam logic [13:0] CENTURY_LIMIT = 14'd100;

  // Weekday sum bias and reciprocals: y/100 = (y*5243)>>19 and
  // s/7 = (s*18725)>>17 are exact for every value below 43690.
  localparam logic [14:0] WD_BIAS   = 15'd7000;
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          SHIFT_100 = 19;
  localparam logic [14:0] RECIP_7   = 15'd18725;
  localparam int          SHIFT_7   = 17;

  typedef struct packed {
    logic capture;
    logic load_date;
    logic walk_init;
    logic walk_step;
    logic commit;
    logic wd1;
    logic wd2;
    logic wd3;
    logic wd4;
    logic out_load;
  } cdda_cmd_t;

  typedef struct packed {
    logic mode;
    logic is_valid;
    logic walk_fwd;
    logic walk_bwd;
  } cdda_status_t;

  // Days in a month; February has 29 days in years divisible by four.
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic [13:0] year);
    logic [4:0] len;
    case (month)
      MONTH_FEB: len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // (31*m)/12 with m the month counted from March (January and February
  // are months 11 and 12 of the previous year).
  function automatic logic [4:0] month_term(input logic [3:0] month);
    logic [4:0] term;
    case (month)
      4'd1:    term = 5'd28;
      4'd2:    term = 5'd31;
      4'd3:    term = 5'd2;
      4'd4:    term = 5'd5;
      4'd5:    term = 5'd7;
      4'd6:    term = 5'd10;
      4'd7:    term = 5'd12;
      4'd8:    term = 5'd15;
      4'd9:    term = 5'd18;
      4'd10:   term = 5'd20;
      4'd11:   term = 5'd23;
      4'd12:   term = 5'd25;
      default: term = 5'd0;
    endcase
    return term;
  endfunction

endpackage

@@ sv/cdda_if.sv @@
// Stream interfaces for the calendar date day adjuster: the item channel
// and the result channel, each with valid, ready and payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface cdda_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [4:0]  load_day;
  logic [3:0]  load_month;
  logic [13:0] load_year;
  logic signed [12:0] delta_days;

  modport source (output valid, mode, load_day, load_month, load_year, delta_days,
                  input ready);
  modport sink (input valid, mode, load_day, load_month, load_year, delta_days,
                output ready);
endinterface

interface cdda_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  out_day;
  logic [3:0]  out_month;
  logic [13:0] out_year;
  logic [2:0]  weekday;
  logic        date_valid;

  modport source (output valid, out_day, out_month, out_year, weekday, date_valid,
                  input ready);
  modport sink (input valid, out_day, out_month, out_year, weekday, date_valid,
                output ready);
endinterface

@@ sv/cdda_ctrl.sv @@
// Controller of the calendar date day adjuster: sequences capture, load or
// month walk, the weekday steps and the result register handoff.
// Depends on cdda_pkg.
`timescale 1ns / 1ps

module cdda_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  cdda_pkg::cdda_status_t status,
  output cdda_pkg::cdda_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_WD1,
    S_WD2,
    S_WD3,
    S_WD4,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;
  logic   in_ready_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   walk_busy;

  assign walk_busy = status.walk_fwd | status.walk_bwd;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.capture  = 1'b1;
          in_ready_nxt = 1'b0;
          state_nxt    = S_START;
        end
      end
      S_START: begin
        if (status.mode == cdda_pkg::MODE_LOAD) begin
          cmd.load_date = 1'b1;
          state_nxt     = S_WD1;
        end else if (status.is_valid) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end else begin
          state_nxt = S_WD1;
        end
      end
      S_WALK: begin
        if (walk_busy) begin
          cmd.walk_step = 1'b1;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_WD1;
        end
      end
      S_WD1: begin
        cmd.wd1   = 1'b1;
        state_nxt = S_WD2;
      end
      S_WD2: begin
        cmd.wd2   = 1'b1;
        state_nxt = S_WD3;
      end
      S_WD3: begin
        cmd.wd3   = 1'b1;
        state_nxt = S_WD4;
      end
      S_WD4: begin
        cmd.wd4   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // The result register is free when empty or being emptied this cycle.
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          in_ready_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        in_ready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted a second item while one is in work");

  a_result_presented: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result was not presented");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !cmd.out_load) |=> !out_valid)
    else $error("result still valid after its transfer");

endmodule

@@ sv/cdda_dp.sv @@
// Datapath of the calendar date day adjuster: the stored date, the load
// check, the month-by-month walk, the weekday steps and the result register.
// Depends on cdda_pkg.
`timescale 1ns / 1ps

module cdda_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cdda_pkg::cdda_cmd_t    cmd,
  output cdda_pkg::cdda_status_t status,
  input  logic                   mode,
  input  logic [4:0]             load_day,
  input  logic [3:0]             load_month,
  input  logic [13:0]            load_year,
  input  logic signed [12:0]     delta_days,
  output logic [4:0]             out_day,
  output logic [3:0]             out_month,
  output logic [13:0]            out_year,
  output logic [2:0]             weekday,
  output logic                   date_valid
);

  // Stored date.
  logic [4:0]  cur_day_r;
  logic [3:0]  cur_month_r;
  logic [13:0] cur_year_r;
  logic        is_valid_r;

  // Captured item.
  logic        mode_r;
  logic [4:0]  day_in_r;
  logic [3:0]  month_in_r;
  logic [13:0] year_in_r;
  logic signed [12:0] delta_r;

  // Walk registers.
  logic signed [13:0] c_r;
  logic [3:0]  m_r;
  logic [13:0] y_r;

  // Weekday step registers.
  logic [13:0] ya_r;
  logic [4:0]  mt_r;
  logic [6:0]  q100_r;
  logic [14:0] sum_r;
  logic [11:0] q7_r;

  // Result register.
  logic [4:0]  out_day_r;
  logic [3:0]  out_month_r;
  logic [13:0] out_year_r;
  logic [2:0]  weekday_r;
  logic        date_valid_r;

  logic [13:0] load_year_adj;
  logic        load_ok;
  logic signed [13:0] c_init;
  logic [4:0]  len_cur;
  logic [3:0]  month_next;
  logic [13:0] year_next;
  logic [3:0]  month_prev;
  logic [13:0] year_prev;
  logic [4:0]  len_prev;
  logic        walk_fwd;
  logic        walk_bwd;
  logic        year_ok;
  logic        early_month;
  logic [26:0] prod100;
  logic [14:0] sum_nxt;
  logic [29:0] prod7;
  logic [14:0] rem;

  assign load_year_adj = (year_in_r < cdda_pkg::CENTURY_LIMIT) ?
                         (year_in_r + cdda_pkg::CENTURY_BASE) : year_in_r;
  assign load_ok = (load_year_adj >= cdda_pkg::YEAR_MIN) &&
                   (load_year_adj <= cdda_pkg::YEAR_MAX) &&
                   (month_in_r >= cdda_pkg::MONTH_JAN) &&
                   (month_in_r <= cdda_pkg::MONTH_DEC) &&
                   (day_in_r != 5'd0) &&
                   (day_in_r <= cdda_pkg::month_len(month_in_r, load_year_adj));

  assign c_init = $signed({9'd0, cur_day_r}) + $signed({delta_r[12], delta_r});

  assign len_cur    = cdda_pkg::month_len(m_r, y_r);
  assign month_next = (m_r == cdda_pkg::MONTH_DEC) ? cdda_pkg::MONTH_JAN : (m_r + 4'd1);
  assign year_next  = (m_r == cdda_pkg::MONTH_DEC) ? (y_r + 14'd1) : y_r;
  assign month_prev = (m_r == cdda_pkg::MONTH_JAN) ? cdda_pkg::MONTH_DEC : (m_r - 4'd1);
  assign year_prev  = (m_r == cdda_pkg::MONTH_JAN) ? (y_r - 14'd1) : y_r;
  assign len_prev   = cdda_pkg::month_len(month_prev, year_prev);

  // Forward steps always end with the count at one or more, so the backward
  // condition is only reached when the walk started below day one.
  assign walk_fwd = c_r > $signed({9'd0, len_cur});
  assign walk_bwd = !walk_fwd && (c_r < 14'sd1);
  assign year_ok  = (y_r >= cdda_pkg::YEAR_MIN) && (y_r <= cdda_pkg::YEAR_MAX);

  assign early_month = (cur_month_r <= cdda_pkg::MONTH_FEB);
  assign prod100 = {13'd0, ya_r} * {14'd0, cdda_pkg::RECIP_100};
  assign sum_nxt = cdda_pkg::WD_BIAS + {10'd0, cur_day_r} + {1'b0, ya_r} +
                   {3'd0, ya_r[13:2]} - {8'd0, q100_r} + {10'd0, q100_r[6:2]} +
                   {10'd0, mt_r};
  assign prod7 = {15'd0, sum_r} * {15'd0, cdda_pkg::RECIP_7};
  assign rem   = sum_r - ({q7_r, 3'd0} - {3'd0, q7_r});

  assign status.mode     = mode_r;
  assign status.is_valid = is_valid_r;
  assign status.walk_fwd = walk_fwd;
  assign status.walk_bwd = walk_bwd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_day_r   <= 5'd0;
      cur_month_r <= 4'd0;
      cur_year_r  <= 14'd0;
      is_valid_r  <= 1'b0;
    end else if (cmd.load_date) begin
      if (load_ok) begin
        cur_day_r   <= day_in_r;
        cur_month_r <= month_in_r;
        cur_year_r  <= load_year_adj;
        is_valid_r  <= 1'b1;
      end else begin
        cur_day_r   <= 5'd0;
        cur_month_r <= 4'd0;
        cur_year_r  <= 14'd0;
        is_valid_r  <= 1'b0;
      end
    end else if (cmd.commit) begin
      if (year_ok) begin
        cur_day_r   <= c_r[4:0];
        cur_month_r <= m_r;
        cur_year_r  <= y_r;
      end else begin
        cur_day_r   <= 5'd0;
        cur_month_r <= 4'd0;
        cur_year_r  <= 14'd0;
        is_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r     <= mode;
      day_in_r   <= load_day;
      month_in_r <= load_month;
      year_in_r  <= load_year;
      delta_r    <= delta_days;
    end
    if (cmd.walk_init) begin
      c_r <= c_init;
      m_r <= cur_month_r;
      y_r <= cur_year_r;
    end else if (cmd.walk_step) begin
      if (walk_fwd) begin
        c_r <= c_r - $signed({9'd0, len_cur});
        m_r <= month_next;
        y_r <= year_next;
      end else begin
        c_r <= c_r + $signed({9'd0, len_prev});
        m_r <= month_prev;
        y_r <= year_prev;
      end
    end
    if (cmd.wd1) begin
      ya_r <= cur_year_r - {13'd0, early_month};
      mt_r <= cdda_pkg::month_term(cur_month_r);
    end
    if (cmd.wd2) begin
      q100_r <= prod100[cdda_pkg::SHIFT_100 +: 7];
    end
    if (cmd.wd3) begin
      sum_r <= sum_nxt;
    end
    if (cmd.wd4) begin
      q7_r <= prod7[cdda_pkg::SHIFT_7 +: 12];
    end
    if (cmd.out_load) begin
      out_day_r    <= is_valid_r ? cur_day_r : 5'd0;
      out_month_r  <= is_valid_r ? cur_month_r : 4'd0;
      out_year_r   <= is_valid_r ? cur_year_r : 14'd0;
      weekday_r    <= is_valid_r ? rem[2:0] : 3'd0;
      date_valid_r <= is_valid_r;
    end
  end

  assign out_day    = out_day_r;
  assign out_month  = out_month_r;
  assign out_year   = out_year_r;
  assign weekday    = weekday_r;
  assign date_valid = date_valid_r;

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !is_valid_r |-> (cur_day_r == 5'd0 && cur_month_r == 4'd0 && cur_year_r == 14'd0))
    else $error("invalid date holds nonzero fields");

  a_valid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    is_valid_r |-> (cur_day_r != 5'd0 && cur_month_r >= cdda_pkg::MONTH_JAN &&
                    cur_month_r <= cdda_pkg::MONTH_DEC &&
                    cur_year_r >= cdda_pkg::YEAR_MIN && cur_year_r <= cdda_pkg::YEAR_MAX))
    else $error("valid date out of range");

  a_store_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.load_date && !cmd.commit) |=>
      ($stable(cur_day_r) && $stable(cur_month_r) && $stable(cur_year_r) &&
       $stable(is_valid_r)))
    else $error("stored date changed without a load or commit");

endmodule

@@ sv/calendar_date_day_adjuster_unit.sv @@
// Top level of the calendar date day adjuster: joins the controller and the
// datapath to the item and result channels.
// Depends on cdda_pkg, cdda_if, cdda_ctrl and cdda_dp.
//
// Usage: each item on in_ch either loads a date (mode 0) or adds the signed
// delta_days to the stored date (mode 1). Every item gives exactly one result
// on out_ch: the stored date after the item, its valid flag and the day of
// week (0 is Sunday). Fields of an invalid date read as zero.
// A load, or an adjust of an invalid date, needs no walk. An adjust of a
// valid date walks month by month over every month boundary crossed (up
// to about 136 for the widest delta); the walk moves one month per cycle.
// The weekday then comes from two registered reciprocal multiplications.
// One item is in work at a time; in_ch.ready rises again as the result is
// written into the output register, so a new item is taken only after the
// previous item's result is written. If the receiver stalls, the result waits
// in that register and the next item is still accepted and worked on;
// it finishes only once that register is freed.
// Reset clears the stored date to invalid with all fields at zero and
// empties the output register.
`timescale 1ns / 1ps

module calendar_date_day_adjuster_unit (
  input logic         clk,
  input logic         rst_n,
  cdda_in_if.sink     in_ch,
  cdda_out_if.source  out_ch
);

  cdda_pkg::cdda_cmd_t    cmd;
  cdda_pkg::cdda_status_t status;

  cdda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  cdda_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .mode       (in_ch.mode),
    .load_day   (in_ch.load_day),
    .load_month (in_ch.load_month),
    .load_year  (in_ch.load_year),
    .delta_days (in_ch.delta_days),
    .out_day    (out_ch.out_day),
    .out_month  (out_ch.out_month),
    .out_year   (out_ch.out_year),
    .weekday    (out_ch.weekday),
    .date_valid (out_ch.date_valid)
  );

endmodule

@@ tb/tb_calendar_date_day_adjuster_unit.sv @@
// Testbench for calendar_date_day_adjuster_unit: a directed table of dates, then random
// load and adjust transfers, each checked against a typed result or a calendar predictor.
// Depends on cdda_pkg, cdda_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_calendar_date_day_adjuster_unit;

  localparam int RANDOM_ITEMS  = 530;
  localparam int QUIET_ITEMS   = 60;
  localparam int SETTLE_CYCLES = 160;
  localparam int MAX_REPORTS   = 10;
  localparam int DIR_ROWS      = 25;

  typedef enum {DRIFT_DOWN, DRIFT_UP, DRIFT_ANY} drift_t;

  typedef struct packed {
    logic        mode;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [12:0] delta;
  } date_cmd_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  weekday;
    logic        ok;
  } date_result_t;

  typedef struct packed {
    date_cmd_t    cmd;
    logic         typed;
    date_result_t result;
  } date_row_t;

  localparam date_result_t NO_DATE = '0;

  // Rows with typed set carry their result; the others are checked against the predictor.
  // Deltas are raw 13-bit patterns: 13'h1FFF is -1, 13'h1000 is -4096.
  localparam date_row_t DIRECTED [DIR_ROWS] = '{
    '{'{cdda_pkg::MODE_ADJUST, 5'd0,  4'd0,  14'd0,     13'd5},    1'b1, NO_DATE},
    '{'{cdda_pkg::MODE_LOAD,   5'd1,  4'd1,  14'd1,     13'd0},    1'b1,
      '{5'd1, 4'd1, 14'd2001, 3'd1, 1'b1}},
    '{'{cdda_pkg::MODE_ADJUST, 5'd0,  4'd0,  14'd0,     13'h1FFF}, 1'b0, NO_DATE},
    '{'{cdda_pkg::MODE_LOAD,   5'd31, 4'd12, 14'd9999,  13'd0},    1'b1,
      '{5'd31, 4'd12, 14'd9999, 3'd5, 1'b1}},
    '{'{cdda_pkg::MODE_ADJUST, 5'd0,  4'd0,  14'd0,     13'd1},    1'b1, NO_DATE},
    '{'{cdda_pkg::MODE_LOAD,   5'd0,  4'd1,  14'd2024,  13'd0},    1'b1, NO_DATE},
    '{'{cdda_pkg::MODE_LOAD,   5'd1,  4'd0,  14'd2024,  13'd0},    1'b1, NO_DATE},
    '{'{cdda_pkg::MODE_LOAD,   5'd1,  4'd13, 14'd2024,  13'd0},    1'b1, NO_DATE},
    '{'{cdda_pkg::MODE_LOAD,   5'd31, 4'd15, 14'd16383, 13'h1FFF}, 1'b1, NO_DATE},
    '{'{cdda_pkg::MODE_LOAD,   5'd1,  4'd1,  14'd10000, 13'd0},    1'b1, NO_DATE},
    '{'{cdda_pkg::MODE_LOAD,   5'd31, 4'd4,  14'd2024,  13'd0},    1'b1, NO_DATE},
    '{'{cdda_pkg::MODE_LOAD,   5'd29, 4'd2,  14'd2023,  13'd0},    1'b1, NO_DATE},
    '{'{cdda_pkg::MODE_LOAD,   5'd30, 4'd2,  14'd2024,  13'd0},    1'b1, NO_DATE},
    '{'{cdda_pkg::MODE_LOAD,   5'd29, 4'd2,  14'd2100,  13'd0},    1'b0, NO_DATE},
    '{'{cdda_pkg::MODE_ADJUST, 5'd31, 4'd15, 14'd16383, 13'd0},    1'b0, NO_DATE},
    '{'{cdda_pkg::MODE_LOAD,   5'd15, 4'd6,  14'd0,     13'd0},    1'b0, NO_DATE},
    '{'{cdda_pkg::MODE_LOAD,   5'd31, 4'd12, 14'd99,    13'd0},    1'b0, NO_DATE},
    '{'{cdda_pkg::MODE_ADJUST, 5'd0,  4'd0,  14'd0,     13'd4095}, 1'b0, NO_DATE},
    '{'{cdda_pkg::MODE_ADJUST, 5'd0,  4'd0,  14'd0,     13'h1000}, 1'b0, NO_DATE},
    '{'{cdda_pkg::MODE_ADJUST, 5'd0,  4'd0,  14'd0,     13'h1000}, 1'b0, NO_DATE},
    '{'{cdda_pkg::MODE_LOAD,   5'd1,  4'd1,  14'd100,   13'd0},    1'b0, NO_DATE},
    '{'{cdda_pkg::MODE_ADJUST, 5'd0,  4'd0,  14'd0,     13'd1},    1'b0, NO_DATE},
    '{'{cdda_pkg::MODE_LOAD,   5'd31, 4'd1,  14'd2024,  13'd0},    1'b0, NO_DATE},
    '{'{cdda_pkg::MODE_ADJUST, 5'd0,  4'd0,  14'd0,     13'd29},   1'b0, NO_DATE},
    '{'{cdda_pkg::MODE_LOAD,   5'd1,  4'd3,  14'd2023,  13'h1FFF}, 1'b0, NO_DATE}
  };

  logic clk;
  logic rst_n;

  cdda_in_if  in_ch ();
  cdda_out_if out_ch ();

  calendar_date_day_adjuster_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predicted contents of the date store.
  int held_day   = 0;
  int held_month = 0;
  int held_year  = 0;
  bit held_ok    = 1'b0;

  date_result_t expected_dates[$];
  int mismatch_count = 0;
  int results_seen   = 0;
  bit quiet_phase    = 1'b0;

  function automatic int month_days(int month, int year);
    if (month == cdda_pkg::MONTH_FEB) return ((year & 3) == 0) ? 29 : 28;
    if (month == cdda_pkg::MONTH_APR || month == cdda_pkg::MONTH_JUN ||
        month == cdda_pkg::MONTH_SEP || month == cdda_pkg::MONTH_NOV)
      return 30;
    return 31;
  endfunction

  // January and February count as months 11 and 12 of the year before.
  function automatic logic [2:0] day_of_week(int day, int month, int year);
    int shift, y, m;
    shift = (month <= 2) ? 1 : 0;
    y = year - shift;
    m = month + 12 * shift - 2;
    return 3'((7000 + day + y + y / 4 - y / 100 + y / 400 + (31 * m) / 12) % 7);
  endfunction

  function automatic date_result_t advance_calendar(date_cmd_t cmd);
    int d, m, y, step;
    date_result_t res;
    if (cmd.mode == cdda_pkg::MODE_LOAD) begin
      d = cmd.day;
      m = cmd.month;
      y = cmd.year;
      if (y < int'(cdda_pkg::CENTURY_LIMIT)) y += int'(cdda_pkg::CENTURY_BASE);
      if (y >= int'(cdda_pkg::YEAR_MIN) && y <= int'(cdda_pkg::YEAR_MAX) &&
          m >= 1 && m <= 12 && d >= 1 && d <= month_days(m, y)) begin
        held_day = d;
        held_month = m;
        held_year = y;
        held_ok = 1'b1;
      end else begin
        held_ok = 1'b0;
      end
    end else if (held_ok) begin
      step = $signed(cmd.delta);
      d = held_day + step;
      m = held_month;
      y = held_year;
      while (d > month_days(m, y)) begin
        d -= month_days(m, y);
        m++;
        if (m > 12) begin
          m = 1;
          y++;
        end
      end
      while (d < 1) begin
        m--;
        if (m < 1) begin
          m = 12;
          y--;
        end
        d += month_days(m, y);
      end
      if (y < int'(cdda_pkg::YEAR_MIN) || y > int'(cdda_pkg::YEAR_MAX)) begin
        held_ok = 1'b0;
      end else begin
        held_day = d;
        held_month = m;
        held_year = y;
      end
    end
    if (!held_ok) begin
      held_day = 0;
      held_month = 0;
      held_year = 0;
      res = NO_DATE;
    end else begin
      res.day = 5'(held_day);
      res.month = 4'(held_month);
      res.year = 14'(held_year);
      res.weekday = day_of_week(held_day, held_month, held_year);
      res.ok = 1'b1;
    end
    return res;
  endfunction

  // A load that starts a run; about one in six is pure noise and mostly rejected.
  function automatic date_cmd_t fresh_date(drift_t drift);
    date_cmd_t cmd;
    int eff_year;
    cmd.mode = cdda_pkg::MODE_LOAD;
    cmd.day = 5'($urandom);
    cmd.month = 4'($urandom);
    cmd.year = 14'($urandom);
    cmd.delta = 13'($urandom);
    if ($urandom_range(0, 5) == 0) return cmd;
    cmd.month = 4'($urandom_range(1, 12));
    case (drift)
      DRIFT_DOWN: cmd.year = 14'($urandom_range(100, 115));
      DRIFT_UP:   cmd.year = 14'($urandom_range(9985, 9999));
      default: begin
        if ($urandom_range(0, 3) == 0) cmd.year = 14'($urandom_range(0, 99));
        else cmd.year = 14'($urandom_range(100, 9999));
      end
    endcase
    eff_year = (cmd.year < cdda_pkg::CENTURY_LIMIT) ?
               int'(cmd.year) + int'(cdda_pkg::CENTURY_BASE) : int'(cmd.year);
    cmd.day = 5'($urandom_range(1, month_days(cmd.month, eff_year)));
    return cmd;
  endfunction

  // Runs that start near either end of the year range lean toward that end.
  function automatic date_cmd_t day_shift(drift_t drift);
    date_cmd_t cmd;
    int span, step;
    cmd.mode = cdda_pkg::MODE_ADJUST;
    cmd.day = 5'($urandom);
    cmd.month = 4'($urandom);
    cmd.year = 14'($urandom);
    case ($urandom_range(0, 3))
      0: span = $urandom_range(0, 40);
      1: span = (drift == DRIFT_ANY) ? $urandom_range(0, 400) : $urandom_range(0, 4096);
      default: span = $urandom_range(0, 4096);
    endcase
    case (drift)
      DRIFT_DOWN: step = ($urandom_range(0, 4) == 0) ? span : -span;
      DRIFT_UP:   step = ($urandom_range(0, 4) == 0) ? -span : span;
      default:    step = ($urandom_range(0, 1) == 0) ? span : -span;
    endcase
    if (step > 4095) step = 4095;
    cmd.delta = 13'(step);
    return cmd;
  endfunction

  task automatic send_cmd(input date_cmd_t cmd, input logic typed, input date_result_t given);
    date_result_t predicted;
    if (!quiet_phase && $urandom_range(0, 6) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= cmd.mode;
    in_ch.load_day <= cmd.day;
    in_ch.load_month <= cmd.month;
    in_ch.load_year <= cmd.year;
    in_ch.delta_days <= cmd.delta;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = advance_calendar(cmd);
    expected_dates.push_back(typed ? given : predicted);
  endtask

  // Holds the sender off until every outstanding result has been received.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_dates.size() != 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : result_sink
    int stall_left;
    date_result_t got, want;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = '{out_ch.out_day, out_ch.out_month, out_ch.out_year, out_ch.weekday,
                out_ch.date_valid};
        results_seen++;
        if (expected_dates.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result %0d arrived with nothing expected: %0d/%0d/%0d wd %0d ok %0b",
                     results_seen, got.day, got.month, got.year, got.weekday, got.ok);
        end else begin
          want = expected_dates.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("result %0d: expected %0d/%0d/%0d wd %0d ok %0b, got %0d/%0d/%0d wd %0d ok %0b",
                       results_seen, want.day, want.month, want.year, want.weekday, want.ok,
                       got.day, got.month, got.year, got.weekday, got.ok);
          end
        end
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (quiet_phase) begin
        out_ch.ready <= 1'b1;
      end else begin
        if (stall_left == 0 && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 18);
        if (stall_left > 0) begin
          stall_left--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    int run_left;
    drift_t drift;
    date_cmd_t cmd;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.mode <= cdda_pkg::MODE_LOAD;
    in_ch.load_day <= '0;
    in_ch.load_month <= '0;
    in_ch.load_year <= '0;
    in_ch.delta_days <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++)
      send_cmd(DIRECTED[r].cmd, DIRECTED[r].typed, DIRECTED[r].result);
    drain_results();

    // Each run is a load followed by a string of adjusts on the loaded date.
    run_left = 0;
    drift = DRIFT_ANY;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_phase = 1'b1;
      if (run_left == 0) begin
        run_left = $urandom_range(2, 16);
        drift = drift_t'($urandom_range(0, 2));
        cmd = fresh_date(drift);
      end else begin
        cmd = day_shift(drift);
      end
      run_left--;
      send_cmd(cmd, 1'b0, NO_DATE);
      if (n % 100 == 99) drain_results();
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_dates.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/cdda_pkg.sv
sv/cdda_if.sv
sv/cdda_ctrl.sv
sv/cdda_dp.sv
sv/calendar_date_day_adjuster_unit.sv
tb/tb_calendar_date_day_adjuster_unit.sv
